// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// implication checked at each rising edge out of reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/gbn_pkg.sv
package gbn_pkg;

   // request type codes
   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_ACK  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // result kind codes
   localparam logic [2:0] KIND_GRANT   = 3'd0;
   localparam logic [2:0] KIND_REFUSE  = 3'd1;
   localparam logic [2:0] KIND_RESEND  = 3'd2;
   localparam logic [2:0] KIND_ACK     = 3'd3;
   localparam logic [2:0] KIND_DROP    = 3'd4;

   // register indexes
   localparam logic [2:0] REG_WINDOW_SIZE = 3'd0;
   localparam logic [2:0] REG_ALPHA       = 3'd1;
   localparam logic [2:0] REG_BETA        = 3'd2;
   localparam logic [2:0] REG_RTT_START   = 3'd3;
   localparam logic [2:0] REG_DEV_START   = 3'd4;
   localparam logic [2:0] REG_RTO_START   = 3'd5;
   localparam logic [2:0] REG_LINK_ID     = 3'd6;
   localparam logic [2:0] REG_FIRST_SEQ   = 3'd7;

   // reset values
   localparam logic [4:0]  RST_WINDOW_SIZE = 5'd8;
   localparam logic [7:0]  RST_ALPHA       = 8'd32;
   localparam logic [7:0]  RST_BETA        = 8'd64;
   localparam logic [15:0] RST_RTT_START   = 16'd100;
   localparam logic [15:0] RST_DEV_START   = 16'd0;
   localparam logic [15:0] RST_RTO_START   = 16'd200;
   localparam logic [31:0] RST_LINK_ID     = 32'd0;
   localparam logic [31:0] RST_FIRST_SEQ   = 32'd2;

   localparam logic [1:0] DUP_TRIGGER  = 2'd3;
   localparam logic [2:0] SAMPLE_EVERY = 3'd5;

   // item class decided by the front end
   typedef enum logic [2:0] {
      CL_NONE,
      CL_SEND,
      CL_ACK,
      CL_DROP,
      CL_TICK
   } gbn_class_type;

   typedef struct packed {
      gbn_class_type cls;
      logic [31:0]   ack_number;
   } gbn_item_type;

   // static configuration seen by front and back
   typedef struct packed {
      logic [4:0]  window_size;
      logic [7:0]  alpha_q8;
      logic [7:0]  beta_q8;
      logic [31:0] link_id;
   } gbn_cfg_type;

   // register write that also loads live state
   typedef struct packed {
      logic        wr;
      logic [2:0]  idx;
      logic [31:0] data;
   } gbn_load_type;

   // truncating divide by 256, toward zero
   function automatic logic signed [34:0] trunc_q8(input logic signed [42:0] p);
      logic [42:0] mag;
      logic [34:0] m;
      mag = p[42] ? 43'(-p) : 43'(p);
      m = mag[42:8];
      return p[42] ? -$signed(m) : $signed(m);
   endfunction

   // saturate to 0 .. 2^32-1
   function automatic logic [31:0] clamp32(input logic signed [36:0] v);
      if (v[36]) begin
         return 32'd0;
      end else if (v[35:32] != 4'd0) begin
         return 32'hFFFF_FFFF;
      end
      return v[31:0];
   endfunction

endpackage

// File: hw/rtl/gbn_if.sv
// request channel
interface gbn_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] ack_number;
   logic [31:0] ack_link_id;
   logic        checksum_good;

   modport source (output valid, req_type, ack_number, ack_link_id, checksum_good,
                   input ready);
   modport sink (input valid, req_type, ack_number, ack_link_id, checksum_good,
                 output ready);
endinterface

// result channel
interface gbn_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] seq_number;
   logic [31:0] timeout_ms;
   logic        last;

   modport source (output valid, kind, seq_number, timeout_ms, last, input ready);
   modport sink (input valid, kind, seq_number, timeout_ms, last, output ready);
endinterface

// File: hw/rtl/gbn_front.sv
// Accepts requests, classifies them and queues them for the back end
module gbn_front (
   input  logic                 clock,
   input  logic                 reset,
   gbn_req_if.sink              req_chan,
   input  gbn_pkg::gbn_cfg_type cfg,
   output logic                 q_valid,
   output gbn_pkg::gbn_item_type q_item,
   input  logic                 q_pop
);

   gbn_pkg::gbn_item_type q_mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   gbn_pkg::gbn_item_type item_in;
   logic push;

   // classify the incoming transaction
   always_comb begin
      item_in.ack_number = req_chan.ack_number;
      case (req_chan.req_type)
         gbn_pkg::REQ_SEND: item_in.cls = gbn_pkg::CL_SEND;
         gbn_pkg::REQ_TICK: item_in.cls = gbn_pkg::CL_TICK;
         gbn_pkg::REQ_ACK: begin
            if (req_chan.checksum_good && req_chan.ack_link_id == cfg.link_id) begin
               item_in.cls = gbn_pkg::CL_ACK;
            end else begin
               item_in.cls = gbn_pkg::CL_DROP;
            end
         end
         default: item_in.cls = gbn_pkg::CL_NONE;
      endcase
   end

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push = req_chan.valid && req_chan.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = q_mem_ff[rd_ptr_ff];

   // two-entry queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

// File: hw/rtl/gbn_back.sv
`include "assert_macros.svh"
// Carries out queued items: window, stamps, resends, slide and estimator
module gbn_back #(
   parameter int WINDOW_MAX = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gbn_pkg::gbn_cfg_type  cfg,
   input  gbn_pkg::gbn_load_type load,
   input  logic                  q_valid,
   input  gbn_pkg::gbn_item_type q_item,
   output logic                  q_pop,
   gbn_rsp_if.source             rsp_chan
);

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TICK_CHK, ST_RESEND, ST_SLIDE, ST_SLIDE_RD,
      ST_EST_A, ST_EST_B, ST_EST_C, ST_EST_D, ST_EMIT
   } state_type;

   state_type state_ff;

   logic [31:0] next_seq_ff, base_ff, now_ff, last_acked_ff;
   logic [31:0] rtt_ff, dev_ff, rto_ff;
   logic [1:0]  dup_ff;
   logic [2:0]  phase_ff;
   logic [SLOT_W-1:0] next_slot_ff, base_slot_ff, res_slot_ff;
   logic [31:0] res_seq_ff;
   logic [CNT_W-1:0] res_cnt_ff, rem_ff;
   logic        ack_pend_ff, sampled_ff;
   logic [31:0] sample_ff;
   logic [32:0] aerr_ff;
   logic signed [42:0] prod_ff;

   // stamp memory
   logic [31:0] stamp_mem [WINDOW_MAX];
   logic [31:0] rd_data_ff;
   logic        mem_we;
   logic [SLOT_W-1:0] mem_waddr;

   // output register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [31:0] rsp_seq_ff, rsp_rto_ff;
   logic        rsp_last_ff;
   logic        rsp_load;
   logic        rsp_valid_in;

   logic        out_free;
   logic [31:0] outstanding, eff_win, ack_dist, acked;
   logic [CNT_W-1:0] freed;
   logic [1:0]  dup_inc;
   logic [2:0]  phase_inc;
   logic signed [32:0] err;
   logic signed [33:0] dev_diff;
   logic signed [34:0] q_val;
   logic [34:0] rto_sum;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
   endfunction

   // window bookkeeping
   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      outstanding = next_seq_ff - base_ff;
      if (cfg.window_size == 5'd0) begin
         eff_win = 32'd1;
      end else if (32'(cfg.window_size) > 32'(WINDOW_MAX)) begin
         eff_win = 32'(WINDOW_MAX);
      end else begin
         eff_win = 32'(cfg.window_size);
      end
      ack_dist = q_item.ack_number - base_ff;
      acked = q_item.ack_number - 32'd1;
      if (ack_dist[31]) begin
         freed = '0;
      end else if (ack_dist < outstanding) begin
         freed = CNT_W'(ack_dist);
      end else begin
         freed = CNT_W'(outstanding);
      end
      dup_inc = dup_ff + 2'd1;
      phase_inc = phase_ff + 3'd1;
      err = $signed({1'b0, sample_ff}) - $signed({1'b0, rtt_ff});
      dev_diff = $signed({1'b0, aerr_ff}) - $signed({2'b0, dev_ff});
      q_val = gbn_pkg::trunc_q8(prod_ff);
      rto_sum = {3'b0, rtt_ff} + {1'b0, dev_ff, 2'b0};
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid && out_free;

   // output register: load a new result or hold one still waiting
   always_comb begin
      case (state_ff)
         ST_IDLE:   rsp_load = q_pop &&
                               (q_item.cls inside {gbn_pkg::CL_SEND, gbn_pkg::CL_DROP});
         ST_RESEND: rsp_load = out_free;
         ST_EMIT:   rsp_load = out_free;
         default:   rsp_load = 1'b0;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   // stamp writes: grant or resend
   always_comb begin
      mem_we = 1'b0;
      mem_waddr = next_slot_ff;
      if (q_pop && q_item.cls == gbn_pkg::CL_SEND && outstanding < eff_win) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_RESEND && out_free && res_cnt_ff != '0) begin
         mem_we = 1'b1;
         mem_waddr = res_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) stamp_mem[mem_waddr] <= now_ff;
      rd_data_ff <= stamp_mem[base_slot_ff];
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind = rsp_kind_ff;
   assign rsp_chan.seq_number = rsp_seq_ff;
   assign rsp_chan.timeout_ms = rsp_rto_ff;
   assign rsp_chan.last = rsp_last_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_seq_ff <= gbn_pkg::RST_FIRST_SEQ;
         base_ff <= gbn_pkg::RST_FIRST_SEQ;
         next_slot_ff <= '0;
         base_slot_ff <= '0;
         now_ff <= 32'd0;
         last_acked_ff <= 32'd0;
         dup_ff <= 2'd0;
         phase_ff <= 3'd0;
         rtt_ff <= 32'(gbn_pkg::RST_RTT_START);
         dev_ff <= 32'(gbn_pkg::RST_DEV_START);
         rto_ff <= 32'(gbn_pkg::RST_RTO_START);
         rsp_valid_ff <= 1'b0;
         ack_pend_ff <= 1'b0;
         sampled_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  case (q_item.cls)
                     gbn_pkg::CL_SEND: begin
                        rsp_seq_ff <= next_seq_ff;
                        rsp_rto_ff <= rto_ff;
                        rsp_last_ff <= 1'b1;
                        if (outstanding < eff_win) begin
                           rsp_kind_ff <= gbn_pkg::KIND_GRANT;
                           next_seq_ff <= next_seq_ff + 32'd1;
                           next_slot_ff <= slot_inc(next_slot_ff);
                        end else begin
                           rsp_kind_ff <= gbn_pkg::KIND_REFUSE;
                        end
                     end
                     gbn_pkg::CL_DROP: begin
                        rsp_kind_ff <= gbn_pkg::KIND_DROP;
                        rsp_seq_ff <= base_ff;
                        rsp_rto_ff <= rto_ff;
                        rsp_last_ff <= 1'b1;
                     end
                     gbn_pkg::CL_TICK: begin
                        now_ff <= now_ff + 32'd1;
                        if (outstanding != 32'd0) state_ff <= ST_TICK_CHK;
                     end
                     gbn_pkg::CL_ACK: begin
                        rem_ff <= freed;
                        sampled_ff <= 1'b0;
                        res_seq_ff <= base_ff;
                        res_slot_ff <= base_slot_ff;
                        res_cnt_ff <= CNT_W'(outstanding);
                        ack_pend_ff <= 1'b1;
                        if (acked == last_acked_ff) begin
                           if (dup_inc == gbn_pkg::DUP_TRIGGER) begin
                              dup_ff <= 2'd0;
                              state_ff <= (outstanding != 32'd0) ? ST_RESEND : ST_SLIDE;
                           end else begin
                              dup_ff <= dup_inc;
                              state_ff <= ST_SLIDE;
                           end
                        end else begin
                           dup_ff <= 2'd0;
                           last_acked_ff <= acked;
                           state_ff <= ST_SLIDE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_TICK_CHK: begin
               res_seq_ff <= base_ff;
               res_slot_ff <= base_slot_ff;
               res_cnt_ff <= CNT_W'(outstanding);
               ack_pend_ff <= 1'b0;
               if ((now_ff - rd_data_ff) > rto_ff) begin
                  state_ff <= ST_RESEND;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RESEND: begin
               if (out_free) begin
                  rsp_kind_ff <= gbn_pkg::KIND_RESEND;
                  rsp_seq_ff <= res_seq_ff;
                  rsp_rto_ff <= rto_ff;
                  rsp_last_ff <= (res_cnt_ff == CNT_W'(1)) && !ack_pend_ff;
                  res_seq_ff <= res_seq_ff + 32'd1;
                  res_slot_ff <= slot_inc(res_slot_ff);
                  res_cnt_ff <= res_cnt_ff - 1'b1;
                  if (res_cnt_ff == CNT_W'(1)) begin
                     state_ff <= ack_pend_ff ? ST_SLIDE : ST_IDLE;
                  end
               end
            end
            ST_SLIDE: begin
               if (rem_ff == '0) begin
                  state_ff <= (sampled_ff && sample_ff != 32'd0) ? ST_EST_A : ST_EMIT;
               end else begin
                  rem_ff <= rem_ff - 1'b1;
                  base_ff <= base_ff + 32'd1;
                  base_slot_ff <= slot_inc(base_slot_ff);
                  if (phase_inc == gbn_pkg::SAMPLE_EVERY) begin
                     phase_ff <= 3'd0;
                     state_ff <= ST_SLIDE_RD;
                  end else begin
                     phase_ff <= phase_inc;
                  end
               end
            end
            ST_SLIDE_RD: begin
               sample_ff <= now_ff - rd_data_ff;
               sampled_ff <= 1'b1;
               state_ff <= ST_SLIDE;
            end
            ST_EST_A: begin
               aerr_ff <= err[32] ? 33'(-err) : 33'(err);
               prod_ff <= 43'($signed({1'b0, cfg.alpha_q8}) * err);
               state_ff <= ST_EST_B;
            end
            ST_EST_B: begin
               rtt_ff <= gbn_pkg::clamp32(37'($signed({1'b0, rtt_ff})) + 37'(q_val));
               prod_ff <= 43'($signed({1'b0, cfg.beta_q8}) * dev_diff);
               state_ff <= ST_EST_C;
            end
            ST_EST_C: begin
               dev_ff <= gbn_pkg::clamp32(37'($signed({1'b0, dev_ff})) + 37'(q_val));
               state_ff <= ST_EST_D;
            end
            ST_EST_D: begin
               rto_ff <= (rto_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : rto_sum[31:0];
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_kind_ff <= gbn_pkg::KIND_ACK;
                  rsp_seq_ff <= base_ff;
                  rsp_rto_ff <= rto_ff;
                  rsp_last_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // register writes that load live state
         if (load.wr) begin
            case (load.idx)
               gbn_pkg::REG_RTT_START: rtt_ff <= {16'd0, load.data[15:0]};
               gbn_pkg::REG_DEV_START: dev_ff <= {16'd0, load.data[15:0]};
               gbn_pkg::REG_RTO_START: rto_ff <= {16'd0, load.data[15:0]};
               gbn_pkg::REG_FIRST_SEQ: begin
                  next_seq_ff <= load.data;
                  base_ff <= load.data;
                  next_slot_ff <= '0;
                  base_slot_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   `ASSERT_ALWAYS(a_window_bound, clock, reset, outstanding <= 32'(WINDOW_MAX))
   `ASSERT_ALWAYS(a_phase_range, clock, reset, phase_ff < gbn_pkg::SAMPLE_EVERY)
   `ASSERT_ALWAYS(a_dup_range, clock, reset, dup_ff != gbn_pkg::DUP_TRIGGER)
   `ASSERT_IMPLIES(a_slot_track, clock, reset, outstanding == 32'd0,
                   next_slot_ff == base_slot_ff)

endmodule

// File: hw/rtl/go_back_n_sender_window.sv
// channel    dir  handshake          payload
// req_chan   in   valid/ready        req_type, ack_number, ack_link_id, checksum_good
// rsp_chan   out  valid/ready        kind, seq_number, timeout_ms, last
// csr        in   APB psel/penable   paddr[4:0], pwdata/prdata 32 bit
//
// Send, drop and quiet tick are handled in the idle state; a tick with packets out adds
// a stamp check. Resend walks every outstanding packet; slide walks each freed packet,
// with an extra stamp read on every fifth, then a closing step; the estimator update
// runs through states EST_A to EST_D. Results that stall hold the sequencer.
// The back end takes a new request only in the idle state with the result register free.
// Reset is synchronous; a two-entry queue lets requests land while results stall.
module go_back_n_sender_window #(
   parameter int WINDOW_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   gbn_req_if.sink     req_chan,
   gbn_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   gbn_pkg::gbn_cfg_type  cfg;
   gbn_pkg::gbn_load_type load;
   logic [15:0] rtt_start_ff, dev_start_ff, rto_start_ff;
   logic [31:0] first_seq_ff;
   logic        q_valid, q_pop;
   gbn_pkg::gbn_item_type q_item;

   assign pready = 1'b1;
   assign load.wr = psel && penable && pwrite;
   assign load.idx = paddr[4:2];
   assign load.data = pwdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg.window_size <= gbn_pkg::RST_WINDOW_SIZE;
         cfg.alpha_q8 <= gbn_pkg::RST_ALPHA;
         cfg.beta_q8 <= gbn_pkg::RST_BETA;
         cfg.link_id <= gbn_pkg::RST_LINK_ID;
         rtt_start_ff <= gbn_pkg::RST_RTT_START;
         dev_start_ff <= gbn_pkg::RST_DEV_START;
         rto_start_ff <= gbn_pkg::RST_RTO_START;
         first_seq_ff <= gbn_pkg::RST_FIRST_SEQ;
      end else if (load.wr) begin
         case (load.idx)
            gbn_pkg::REG_WINDOW_SIZE: cfg.window_size <= pwdata[4:0];
            gbn_pkg::REG_ALPHA: cfg.alpha_q8 <= pwdata[7:0];
            gbn_pkg::REG_BETA: cfg.beta_q8 <= pwdata[7:0];
            gbn_pkg::REG_RTT_START: rtt_start_ff <= pwdata[15:0];
            gbn_pkg::REG_DEV_START: dev_start_ff <= pwdata[15:0];
            gbn_pkg::REG_RTO_START: rto_start_ff <= pwdata[15:0];
            gbn_pkg::REG_LINK_ID: cfg.link_id <= pwdata;
            gbn_pkg::REG_FIRST_SEQ: first_seq_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (paddr[4:2])
         gbn_pkg::REG_WINDOW_SIZE: prdata = 32'(cfg.window_size);
         gbn_pkg::REG_ALPHA: prdata = 32'(cfg.alpha_q8);
         gbn_pkg::REG_BETA: prdata = 32'(cfg.beta_q8);
         gbn_pkg::REG_RTT_START: prdata = 32'(rtt_start_ff);
         gbn_pkg::REG_DEV_START: prdata = 32'(dev_start_ff);
         gbn_pkg::REG_RTO_START: prdata = 32'(rto_start_ff);
         gbn_pkg::REG_LINK_ID: prdata = cfg.link_id;
         gbn_pkg::REG_FIRST_SEQ: prdata = first_seq_ff;
         default: prdata = 32'd0;
      endcase
   end

   gbn_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .cfg(cfg),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   gbn_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .load(load),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .rsp_chan(rsp_chan)
   );

endmodule

// File: tb/tb_go_back_n_sender_window.sv
module tb_go_back_n_sender_window;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;
   // request type that the block ignores
   localparam logic [1:0] REQ_SPARE = 2'd3;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   gbn_req_if req_chan ();
   gbn_rsp_if rsp_chan ();

   go_back_n_sender_window #(.WINDOW_MAX(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] seq;
      logic [31:0] tmo;
      logic        last;
   } window_event_type;

   window_event_type due_events[$];
   int            errors = 0;
   bit            calm = 0;

   // shadow registers and window state
   logic [4:0]  win_size;
   logic [7:0]  gain_rtt, gain_dev;
   logic [31:0] conn_id;
   logic [31:0] nxt, base, clk_ms, prev_acked, rtt_est, rtt_dev, rto;
   logic [31:0] stamps [SLOTS];
   logic [1:0]  dup_cnt;
   logic [2:0]  free_cnt;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("tb_go_back_n_sender_window: errors");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [31:0] sat32(input longint v);
      if (v < 0) return 32'd0;
      if (v > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return v[31:0];
   endfunction

   function automatic void push_event(input logic [2:0] kind, input logic [31:0] seq);
      window_event_type e;
      e.kind = kind; e.seq = seq; e.tmo = rto; e.last = 1'b0;
      due_events.push_back(e);
   endfunction

   function automatic void resend_window();
      logic [31:0] n;
      n = nxt - base;
      for (int i = 0; i < n && i < SLOTS; i++) begin
         stamps[(base + i) % SLOTS] = clk_ms;
         push_event(gbn_pkg::KIND_RESEND, base + i);
      end
   endfunction

   function automatic void update_rto(input logic [31:0] sample);
      longint err, aerr, s, r, d;
      s = sample; r = rtt_est; d = rtt_dev;
      err = s - r;
      aerr = err < 0 ? -err : err;
      rtt_est = sat32(r + (longint'(gain_rtt) * err) / 256);
      rtt_dev = sat32(d + (longint'(gain_dev) * (aerr - d)) / 256);
      rto = sat32(longint'(rtt_est) + 4 * longint'(rtt_dev));
   endfunction

   // expected results of one accepted transaction
   function automatic void predict_window(input logic [1:0] rt, input logic [31:0] an,
                                          input logic [31:0] al, input logic cg);
      int          prior;
      logic [31:0] outst, eff, d, freed, sample;
      bit          sampled;
      prior = due_events.size();
      outst = nxt - base;
      eff = (win_size == 5'd0) ? 32'd1 :
            ((32'(win_size) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(win_size));
      sampled = 0; sample = 0;
      if (rt == gbn_pkg::REQ_SEND) begin
         if (outst < eff) begin
            stamps[nxt % SLOTS] = clk_ms;
            push_event(gbn_pkg::KIND_GRANT, nxt);
            nxt++;
         end else begin
            push_event(gbn_pkg::KIND_REFUSE, nxt);
         end
      end else if (rt == gbn_pkg::REQ_TICK) begin
         clk_ms++;
         if (outst != 0 && (clk_ms - stamps[base % SLOTS]) > rto) resend_window();
      end else if (rt == gbn_pkg::REQ_ACK) begin
         if (!cg || al != conn_id) begin
            push_event(gbn_pkg::KIND_DROP, base);
         end else begin
            if (an - 1 == prev_acked) begin
               dup_cnt++;
               if (dup_cnt >= gbn_pkg::DUP_TRIGGER) begin
                  dup_cnt = 0;
                  resend_window();
               end
            end else begin
               dup_cnt = 0;
               prev_acked = an - 1;
            end
            d = an - base;
            freed = d[31] ? 0 : (d < outst ? d : outst);
            for (int i = 0; i < freed; i++) begin
               free_cnt++;
               if (free_cnt >= gbn_pkg::SAMPLE_EVERY) begin
                  free_cnt = 0;
                  sample = clk_ms - stamps[base % SLOTS];
                  sampled = 1;
               end
               base++;
            end
            if (sampled && sample != 0) update_rto(sample);
            push_event(gbn_pkg::KIND_ACK, base);
         end
      end
      if (due_events.size() > prior) due_events[due_events.size() - 1].last = 1'b1;
   endfunction

   // register write, setup then access; called at a falling edge
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      case (idx)
         gbn_pkg::REG_WINDOW_SIZE: win_size = val[4:0];
         gbn_pkg::REG_ALPHA:       gain_rtt = val[7:0];
         gbn_pkg::REG_BETA:        gain_dev = val[7:0];
         gbn_pkg::REG_RTT_START:   rtt_est = 32'(val[15:0]);
         gbn_pkg::REG_DEV_START:   rtt_dev = 32'(val[15:0]);
         gbn_pkg::REG_RTO_START:   rto = 32'(val[15:0]);
         gbn_pkg::REG_LINK_ID:     conn_id = val;
         gbn_pkg::REG_FIRST_SEQ: begin
            nxt = val; base = val;
         end
         default: ;
      endcase
   endtask

   // one request transaction; entered and left at a falling edge
   task automatic send_item(input logic [1:0] rt, input logic [31:0] an = 0,
                            input logic [31:0] al = 0, input logic cg = 1);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_chan.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_chan.req_type = rt; req_chan.ack_number = an;
      req_chan.ack_link_id = al; req_chan.checksum_good = cg;
      req_chan.valid = 1;
      do @(posedge clock); while (!req_chan.ready);
      predict_window(rt, an, al, cg);
      @(negedge clock);
   endtask

   task automatic ack_to(input logic [31:0] an);
      send_item(gbn_pkg::REQ_ACK, an, conn_id, 1);
   endtask

   // wait for every expected result, then for the block to settle
   task automatic drain();
      req_chan.valid = 0;
      do @(posedge clock); while (due_events.size() != 0);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   // result consumer with random back-pressure
   initial begin
      int stall;
      rsp_chan.ready = 0;
      @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_chan.ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      window_event_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_events.size() == 0) begin
            report("unexpected result kind", 32'(rsp_chan.kind), 32'd0);
         end else begin
            e = due_events.pop_front();
            if (rsp_chan.kind !== e.kind) report("kind", 32'(rsp_chan.kind), 32'(e.kind));
            if (rsp_chan.seq_number !== e.seq) report("seq_number", rsp_chan.seq_number, e.seq);
            if (rsp_chan.timeout_ms !== e.tmo) report("timeout_ms", rsp_chan.timeout_ms, e.tmo);
            if (rsp_chan.last !== e.last) report("last", 32'(rsp_chan.last), 32'(e.last));
         end
      end
   end

   task automatic test_window_fill();
      repeat (9) send_item(gbn_pkg::REQ_SEND);
      ack_to(base + 8);
   endtask

   task automatic test_drops();
      send_item(gbn_pkg::REQ_SEND);
      send_item(gbn_pkg::REQ_ACK, base + 1, conn_id, 0);
      send_item(gbn_pkg::REQ_ACK, base + 1, 32'hFFFF_FFFF, 1);
      send_item(REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
   endtask

   task automatic test_dup_resend();
      send_item(gbn_pkg::REQ_SEND);
      send_item(gbn_pkg::REQ_SEND);
      repeat (4) ack_to(base);
      ack_to(nxt);
   endtask

   task automatic test_timeout();
      drain();
      csr_write(gbn_pkg::REG_RTO_START, 1);
      csr_write(gbn_pkg::REG_ALPHA, 255);
      csr_write(gbn_pkg::REG_BETA, 255);
      calm = 1;
      repeat (5) send_item(gbn_pkg::REQ_SEND);
      repeat (4) send_item(gbn_pkg::REQ_TICK);
      ack_to(nxt);
      calm = 0;
   endtask

   task automatic test_seq_wrap();
      drain();
      csr_write(gbn_pkg::REG_FIRST_SEQ, 32'hFFFF_FFFE);
      csr_write(gbn_pkg::REG_WINDOW_SIZE, 16);
      csr_write(gbn_pkg::REG_LINK_ID, 32'hFFFF_FFFF);
      repeat (17) send_item(gbn_pkg::REQ_SEND);
      ack_to(base - 5);
      ack_to(nxt);
   endtask

   task automatic random_phase(input int count);
      int pick, outst;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         outst = nxt - base;
         if (pick < 35) begin
            send_item(gbn_pkg::REQ_SEND);
         end else if (pick < 55) begin
            ack_to(base + $urandom_range(0, outst));
         end else if (pick < 62) begin
            ack_to(prev_acked + 1);
         end else if (pick < 66) begin
            send_item(gbn_pkg::REQ_ACK, $urandom, conn_id, 1);
         end else if (pick < 72) begin
            if ($urandom_range(0, 1)) send_item(gbn_pkg::REQ_ACK, $urandom, conn_id, 0);
            else send_item(gbn_pkg::REQ_ACK, $urandom,
                           conn_id ^ (32'd1 << $urandom_range(0, 31)), 1);
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 6))
               send_item(gbn_pkg::REQ_TICK, $urandom, $urandom, 1'($urandom));
         end else begin
            send_item(REQ_SPARE, $urandom, $urandom, 1'($urandom));
         end
      end
   endtask

   task automatic test_random();
      for (int p = 0; p < 8; p++) begin
         drain();
         case (p)
            0: csr_write(gbn_pkg::REG_WINDOW_SIZE, 0);
            1: csr_write(gbn_pkg::REG_WINDOW_SIZE, 31);
            2: csr_write(gbn_pkg::REG_WINDOW_SIZE, 1);
            default: csr_write(gbn_pkg::REG_WINDOW_SIZE, $urandom_range(2, 16));
         endcase
         csr_write(gbn_pkg::REG_ALPHA, p == 0 ? 0 : (p == 1 ? 255 : $urandom_range(0, 255)));
         csr_write(gbn_pkg::REG_BETA, p == 0 ? 0 : (p == 1 ? 255 : $urandom_range(0, 255)));
         csr_write(gbn_pkg::REG_RTT_START,
                   p == 1 ? 65535 : (p == 0 ? 0 : $urandom_range(0, 20)));
         csr_write(gbn_pkg::REG_DEV_START, p == 1 ? 65535 : $urandom_range(0, 5));
         csr_write(gbn_pkg::REG_RTO_START, p == 1 ? 65535 : $urandom_range(1, 6));
         csr_write(gbn_pkg::REG_LINK_ID, p == 0 ? 0 : $urandom);
         csr_write(gbn_pkg::REG_FIRST_SEQ, p == 3 ? 32'hFFFF_FFF8 : $urandom);
         calm = (p == 5);
         random_phase(5);
      end
      calm = 0;
   endtask

   initial begin
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      req_chan.valid = 0; req_chan.req_type = gbn_pkg::REQ_SEND; req_chan.ack_number = 0;
      req_chan.ack_link_id = 0; req_chan.checksum_good = 0;
      win_size = gbn_pkg::RST_WINDOW_SIZE; gain_rtt = gbn_pkg::RST_ALPHA;
      gain_dev = gbn_pkg::RST_BETA;
      conn_id = gbn_pkg::RST_LINK_ID; nxt = gbn_pkg::RST_FIRST_SEQ;
      base = gbn_pkg::RST_FIRST_SEQ;
      clk_ms = 0; prev_acked = 0; dup_cnt = 0; free_cnt = 0;
      rtt_est = 32'(gbn_pkg::RST_RTT_START); rtt_dev = 32'(gbn_pkg::RST_DEV_START);
      rto = 32'(gbn_pkg::RST_RTO_START);
      foreach (stamps[i]) stamps[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_window_fill();
      test_drops();
      test_dup_resend();
      test_timeout();
      test_seq_wrap();
      test_random();
      drain();

      if (errors == 0) begin
         $display("tb_go_back_n_sender_window: clean");
      end else begin
         $display("tb_go_back_n_sender_window: errors");
      end
      $finish;
   end

endmodule
